// ===== rtl/plc_pkg.sv =====
// ----------------------------------------------------------------------------
// plc_pkg
// shared constants, types and operation codes of the positional list engine
// ----------------------------------------------------------------------------
package plc_pkg;

	localparam int CAPACITY = 64;
	localparam int ELEM_W   = 32;
	localparam int POS_W    = 8;
	localparam int OP_W     = 3;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	// compare width: holds any position or count plus one
	localparam int CMP_W    = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

	localparam int IN_W     = OP_W + POS_W + ELEM_W;
	localparam int IN_TW    = ((IN_W + 7) / 8) * 8;
	localparam int OUT_W    = 1 + ELEM_W + CNT_W + 1 + ELEM_W;
	localparam int OUT_TW   = ((OUT_W + 7) / 8) * 8;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT  = 3'd0,
		OP_REPLACE = 3'd1,
		OP_DELETE  = 3'd2,
		OP_READ    = 3'd3,
		OP_CLEAR   = 3'd4
	} op_t;

	typedef logic [ELEM_W-1:0] elem_t;

	// per-cycle command broadcast to every cell
	typedef struct packed {
		logic             wr;      // load the new element at wr_idx
		logic             shr;     // cells in (lo, hi] take their left neighbor
		logic             shl;     // cells in [lo, hi) take their right neighbor
		logic [CMP_W-1:0] wr_idx;
		logic [CMP_W-1:0] lo;
		logic [CMP_W-1:0] hi;
	} cell_cmd_t;

	// selection request toward the read and tail reduction
	typedef struct packed {
		logic             rd_en;
		logic [IDX_W-1:0] rd_idx;
		logic             tail_en;
		logic [IDX_W-1:0] tail_idx;
	} sel_req_t;

endpackage

// ===== rtl/plc_cell.sv =====
// ----------------------------------------------------------------------------
// plc_cell
// one storage cell of the list; loads, shifts right or shifts left
// ----------------------------------------------------------------------------
module plc_cell (
	input  logic                          clk,
	input  logic [plc_pkg::IDX_W-1:0]     idx,
	input  plc_pkg::cell_cmd_t            cmd,
	input  plc_pkg::elem_t                elem,
	input  plc_pkg::elem_t                left,
	input  plc_pkg::elem_t                right,
	output plc_pkg::elem_t                data
);

	logic [plc_pkg::CMP_W-1:0] my_idx;
	plc_pkg::elem_t            data_q;

	assign my_idx = plc_pkg::CMP_W'(idx);
	assign data   = data_q;

	// payload only, no reset needed
	always_ff @(posedge clk) begin
		if (cmd.wr && my_idx == cmd.wr_idx) begin
			data_q <= elem;
		end else if (cmd.shr && my_idx > cmd.lo && my_idx <= cmd.hi) begin
			data_q <= left;
		end else if (cmd.shl && my_idx >= cmd.lo && my_idx < cmd.hi) begin
			data_q <= right;
		end
	end

endmodule

// ===== rtl/plc_select.sv =====
// ----------------------------------------------------------------------------
// plc_select
// and-or reduction over the cell row for the read and tail elements
// ----------------------------------------------------------------------------
module plc_select (
	input  plc_pkg::elem_t   cells [plc_pkg::CAPACITY],
	input  plc_pkg::sel_req_t req,
	output plc_pkg::elem_t   rd_data,
	output plc_pkg::elem_t   tail_data
);

	always_comb begin
		rd_data   = '0;
		tail_data = '0;
		for (int i = 0; i < plc_pkg::CAPACITY; i++) begin
			if (req.rd_en && req.rd_idx == plc_pkg::IDX_W'(i)) begin
				rd_data = rd_data | cells[i];
			end
			if (req.tail_en && req.tail_idx == plc_pkg::IDX_W'(i)) begin
				tail_data = tail_data | cells[i];
			end
		end
	end

endmodule

// ===== rtl/positional_list_engine_top.sv =====
// ----------------------------------------------------------------------------
// positional_list_engine_top
// ordered list of element handles held in a row of shifting cells
// ----------------------------------------------------------------------------
// The list lives in a row of CAPACITY cells, one entry per cell, position 0 in
// cell 0. An insert moves every cell from the target position up one place to
// the right in the same clock, a delete moves the cells above the position one
// place to the left, so every successful insert, replace or delete changes the
// row in the cycle the item is accepted. In the cycle after, a single stage
// picks the read and tail elements out of the row to build the result, which
// then sits in the output register. The block takes one item per clock as long
// as the output side keeps taking results. A stalled output holds the stage,
// and then no new item is taken. After reset the list is empty; cell contents
// are not cleared and are never shown before they are written.
// ----------------------------------------------------------------------------
module positional_list_engine_top (
	input  logic                         clk,
	input  logic                         arst_n,
	// input items
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// [2:0] operation, [10:3] position, [42:11] element, rest zero
	input  logic [plc_pkg::IN_TW-1:0]    s_tdata,
	// result items
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// [0] status, [32:1] element_out, [39:33] entry_count, [40] is_empty,
	// [72:41] last_element, rest zero
	output logic [plc_pkg::OUT_TW-1:0]   m_tdata
);

	// ---------------------------------------------------------------- fields
	logic [plc_pkg::OP_W-1:0]   operation;
	logic [plc_pkg::POS_W-1:0]  position;
	plc_pkg::elem_t             element;

	assign operation = s_tdata[plc_pkg::OP_W-1:0];
	assign position  = s_tdata[plc_pkg::OP_W +: plc_pkg::POS_W];
	assign element   = s_tdata[plc_pkg::OP_W + plc_pkg::POS_W +: plc_pkg::ELEM_W];

	// ---------------------------------------------------------------- handshake
	logic accept;
	logic advance;
	logic valid_s1;
	logic out_valid_q;

	// stage 1 moves into the output register whenever that register is empty or its result is taken
	assign advance  = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;

	// ---------------------------------------------------------------- decode
	logic [plc_pkg::CNT_W-1:0]  count_q;
	logic [plc_pkg::CMP_W-1:0]  cnt_ext;
	logic [plc_pkg::CMP_W-1:0]  pos_ext;
	logic [plc_pkg::CMP_W-1:0]  ins_target;
	logic                       full;
	plc_pkg::cell_cmd_t         cmd;
	logic [plc_pkg::CNT_W-1:0]  count_nxt;
	logic                       status_nxt;
	logic                       rd_en_nxt;

	assign cnt_ext    = plc_pkg::CMP_W'(count_q);
	assign pos_ext    = plc_pkg::CMP_W'(position);
	assign full       = count_q == plc_pkg::CNT_W'(plc_pkg::CAPACITY);
	// a position at or past the count appends
	assign ins_target = (pos_ext >= cnt_ext) ? cnt_ext : pos_ext;

	always_comb begin
		cmd        = '0;
		count_nxt  = count_q;
		status_nxt = 1'b0;
		rd_en_nxt  = 1'b0;
		case (plc_pkg::op_t'(operation))
			plc_pkg::OP_INSERT: begin
				if (full) begin
					status_nxt = 1'b1;
				end else begin
					cmd.wr     = 1'b1;
					cmd.wr_idx = ins_target;
					cmd.shr    = 1'b1;
					cmd.lo     = ins_target;
					cmd.hi     = cnt_ext;
					count_nxt  = count_q + 1'b1;
				end
			end
			plc_pkg::OP_REPLACE: begin
				if (pos_ext >= cnt_ext) begin
					status_nxt = 1'b1;
				end else begin
					cmd.wr     = 1'b1;
					cmd.wr_idx = pos_ext;
				end
			end
			plc_pkg::OP_DELETE: begin
				if (count_q == '0) begin
					status_nxt = 1'b1;
				end else begin
					// empty range when the position is at or past the tail
					cmd.shl   = 1'b1;
					cmd.lo    = pos_ext;
					cmd.hi    = cnt_ext - 1'b1;
					count_nxt = count_q - 1'b1;
				end
			end
			plc_pkg::OP_READ: begin
				if (pos_ext >= cnt_ext) begin
					status_nxt = 1'b1;
				end else begin
					rd_en_nxt = 1'b1;
				end
			end
			plc_pkg::OP_CLEAR: begin
				count_nxt = '0;
			end
			default: begin
				status_nxt = 1'b1;
			end
		endcase
	end

	// the row only moves on an accepted item
	plc_pkg::cell_cmd_t cell_cmd;
	assign cell_cmd = accept ? cmd : '0;

	// ---------------------------------------------------------------- cell row
	plc_pkg::elem_t cells [plc_pkg::CAPACITY];

	for (genvar i = 0; i < plc_pkg::CAPACITY; i++) begin : g_cell
		plc_pkg::elem_t left_d;
		plc_pkg::elem_t right_d;
		if (i == 0) begin : g_first
			assign left_d = '0;
		end else begin : g_mid_l
			assign left_d = cells[i-1];
		end
		if (i == plc_pkg::CAPACITY - 1) begin : g_last
			assign right_d = '0;
		end else begin : g_mid_r
			assign right_d = cells[i+1];
		end
		plc_cell u_cell (
			.clk   (clk),
			.idx   (plc_pkg::IDX_W'(i)),
			.cmd   (cell_cmd),
			.elem  (element),
			.left  (left_d),
			.right (right_d),
			.data  (cells[i])
		);
	end

	// ---------------------------------------------------------------- stage 1
	logic                       status_s1;
	logic                       rd_en_s1;
	logic [plc_pkg::IDX_W-1:0]  rd_idx_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				count_q  <= count_nxt;
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= status_nxt;
			rd_en_s1  <= rd_en_nxt;
			// a successful read is below the count, so it fits the index
			rd_idx_s1 <= position[plc_pkg::IDX_W-1:0];
		end
	end

	// count_q already holds the count after the item in stage 1
	plc_pkg::sel_req_t sel_req;
	plc_pkg::elem_t    rd_data;
	plc_pkg::elem_t    tail_data;
	logic [plc_pkg::CNT_W-1:0] tail_cnt;

	assign tail_cnt         = count_q - 1'b1;
	assign sel_req.rd_en    = rd_en_s1;
	assign sel_req.rd_idx   = rd_idx_s1;
	assign sel_req.tail_en  = count_q != '0;
	assign sel_req.tail_idx = tail_cnt[plc_pkg::IDX_W-1:0];

	plc_select u_select (
		.cells     (cells),
		.req       (sel_req),
		.rd_data   (rd_data),
		.tail_data (tail_data)
	);

	// ---------------------------------------------------------------- output
	logic                       out_status_q;
	plc_pkg::elem_t             out_elem_q;
	logic [plc_pkg::CNT_W-1:0]  out_count_q;
	logic                       out_empty_q;
	plc_pkg::elem_t             out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			out_status_q <= status_s1;
			out_elem_q   <= rd_data;
			out_count_q  <= count_q;
			out_empty_q  <= count_q == '0;
			out_last_q   <= tail_data;
		end
	end

	assign m_tdata = plc_pkg::OUT_TW'({out_last_q, out_empty_q, out_count_q,
		out_elem_q, out_status_q});

	// ---------------------------------------------------------------- checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= plc_pkg::CNT_W'(plc_pkg::CAPACITY))
		else $error("list count past capacity");

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid_q && !m_tready) |-> !s_tready)
		else $error("input taken while result stage is stalled");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && operation == plc_pkg::OP_CLEAR) |=> count_q == '0)
		else $error("clear left entries in the list");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_empty_q == (out_count_q == '0)))
		else $error("empty flag disagrees with count");

	a_full_insert_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && operation == plc_pkg::OP_INSERT && full) |=> $stable(count_q))
		else $error("insert into full list changed the count");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the positional list engine
// ----------------------------------------------------------------------------
// A short table of directed items walks the empty, single-entry and error
// corners. Rows with an obvious outcome carry it typed in. Every other row,
// and the random phases after it, are checked against a shadow list kept
// in this bench. The random phases lean toward filling, draining or mixing
// the list, so full and empty both get exercised. The sender works in bursts
// and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb;
	import plc_pkg::*;

	localparam int IN_W_USED  = OP_W + POS_W + ELEM_W;
	localparam int OUT_W_USED = 1 + ELEM_W + CNT_W + 1 + ELEM_W;
	localparam int RUN_LIMIT  = 400000;
	localparam int SETTLE     = 10;
	localparam int MAX_SHOWN  = 10;

	// operation codes the package leaves unnamed
	localparam logic [OP_W-1:0] OP_RSVD5 = 3'd5;
	localparam logic [OP_W-1:0] OP_RSVD6 = 3'd6;
	localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;

	localparam logic ST_OK  = 1'b0;
	localparam logic ST_ERR = 1'b1;

	// random phase flavors
	localparam int PH_FILL  = 0;
	localparam int PH_DRAIN = 1;
	localparam int PH_MIX   = 2;

	// receiver stall patterns
	localparam logic [1:0] RCV_STEADY = 2'd0;
	localparam logic [1:0] RCV_SKIP   = 2'd1;
	localparam logic [1:0] RCV_COIN   = 2'd2;
	localparam logic [1:0] RCV_LONG   = 2'd3;

	// input item, operation in the lowest bits
	typedef struct packed {
		elem_t             element;
		logic [POS_W-1:0]  position;
		logic [OP_W-1:0]   operation;
	} list_item_t;

	// result item, status in the lowest bit
	typedef struct packed {
		elem_t             last_element;
		logic              is_empty;
		logic [CNT_W-1:0]  entry_count;
		elem_t             element_out;
		logic              status;
	} list_result_t;

	typedef struct packed {
		list_item_t        item;
		logic              typed;
		list_result_t      want;
	} stim_row_t;

	logic                clk      = 1'b0;
	logic                arst_n   = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [IN_TW-1:0]    s_tdata  = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [OUT_TW-1:0]   m_tdata;

	positional_list_engine_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// shadow copy of the list
	elem_t          shadow_cells [CAPACITY];
	int             shadow_len = 0;
	list_result_t   pending_results [$];
	stim_row_t      directed_rows [$];
	int             bad_results = 0;
	int             burst_left = 0;
	bit             calm = 1'b0;
	logic [15:0]    rcv_tick = '0;
	logic [1:0]     rcv_mode = RCV_STEADY;
	int             rcv_left = 0;
	int             cycle_cnt = 0;

	int phase_kind [9] = '{PH_FILL, PH_MIX, PH_FILL, PH_DRAIN, PH_DRAIN,
		PH_MIX, PH_FILL, PH_DRAIN, PH_MIX};
	int phase_len  [9] = '{150, 100, 120, 150, 80, 100, 150, 130, 100};
	bit phase_calm [9] = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0};

	// apply one operation to the shadow list and give the result it produces
	function automatic list_result_t apply_list_op(input list_item_t it);
		list_result_t r;
		int p;
		int i;
		r = '0;
		r.status = ST_OK;
		p = it.position;
		case (it.operation)
			OP_INSERT: begin
				if (shadow_len >= CAPACITY) begin
					r.status = ST_ERR;
				end else if (p >= shadow_len) begin
					// at or past the end: append
					shadow_cells[shadow_len] = it.element;
					shadow_len++;
				end else begin
					for (i = shadow_len; i > p; i--)
						shadow_cells[i] = shadow_cells[i-1];
					shadow_cells[p] = it.element;
					shadow_len++;
				end
			end
			OP_REPLACE: begin
				if (p >= shadow_len)
					r.status = ST_ERR;
				else
					shadow_cells[p] = it.element;
			end
			OP_DELETE: begin
				if (shadow_len == 0) begin
					r.status = ST_ERR;
				end else begin
					// a position at or past the tail removes the tail
					for (i = p; i + 1 < shadow_len; i++)
						shadow_cells[i] = shadow_cells[i+1];
					shadow_len--;
				end
			end
			OP_READ: begin
				if (p >= shadow_len)
					r.status = ST_ERR;
				else
					r.element_out = shadow_cells[p];
			end
			OP_CLEAR: begin
				shadow_len = 0;
			end
			default: begin
				r.status = ST_ERR;
			end
		endcase
		r.entry_count  = CNT_W'(shadow_len);
		r.is_empty     = (shadow_len == 0);
		r.last_element = (shadow_len > 0) ? shadow_cells[shadow_len-1] : '0;
		return r;
	endfunction

	function automatic list_result_t res(input logic st, input elem_t eo,
		input int cnt, input logic emp, input elem_t last);
		list_result_t r;
		r.status       = st;
		r.element_out  = eo;
		r.entry_count  = CNT_W'(cnt);
		r.is_empty     = emp;
		r.last_element = last;
		return r;
	endfunction

	function automatic stim_row_t row(input logic [OP_W-1:0] op, input int pos,
		input elem_t el, input logic typed, input list_result_t want);
		stim_row_t r;
		r.item.operation = op;
		r.item.position  = POS_W'(pos);
		r.item.element   = el;
		r.typed          = typed;
		r.want           = want;
		return r;
	endfunction

	// random item, operation mix depends on the phase flavor
	function automatic stim_row_t rand_row(input int kind);
		stim_row_t r;
		int pick;
		int t_ins;
		int t_del;
		int t_rep;
		int t_rd;
		int t_clr;
		logic [OP_W-1:0] op;
		int pos;
		elem_t el;
		case (kind)
			PH_FILL:  begin t_ins = 75; t_del = 85; t_rep = 90; t_rd = 97; t_clr = 98; end
			PH_DRAIN: begin t_ins = 10; t_del = 80; t_rep = 85; t_rd = 95; t_clr = 96; end
			default:  begin t_ins = 30; t_del = 55; t_rep = 70; t_rd = 92; t_clr = 95; end
		endcase
		pick = $urandom_range(0, 99);
		if (pick < t_ins)
			op = OP_INSERT;
		else if (pick < t_del)
			op = OP_DELETE;
		else if (pick < t_rep)
			op = OP_REPLACE;
		else if (pick < t_rd)
			op = OP_READ;
		else if (pick < t_clr)
			op = OP_CLEAR;
		else begin
			case ($urandom_range(0, 2))
				0:       op = OP_RSVD5;
				1:       op = OP_RSVD6;
				default: op = OP_RSVD7;
			endcase
		end
		// positions cluster around the live range, with some wild ones
		pick = $urandom_range(0, 99);
		if (pick < 55)
			pos = $urandom_range(0, shadow_len);
		else if (pick < 65)
			pos = 0;
		else if (pick < 80)
			pos = (shadow_len == 0) ? 0 : shadow_len - 1;
		else if (pick < 85)
			pos = shadow_len;
		else if (pick < 95)
			pos = $urandom_range(0, 255);
		else
			pos = 255;
		pick = $urandom_range(0, 99);
		if (pick < 85)
			el = $urandom;
		else if (pick < 90)
			el = '0;
		else if (pick < 95)
			el = '1;
		else
			el = elem_t'(1) << $urandom_range(0, ELEM_W - 1);
		r = row(op, pos, el, 1'b0, '0);
		return r;
	endfunction

	// offer one item, record its expected result once it is taken
	task automatic send_row(input stim_row_t r);
		list_result_t pred;
		s_tvalid <= 1'b1;
		s_tdata  <= {{(IN_TW - IN_W_USED){1'b0}}, r.item};
		do @(posedge clk); while (!s_tready);
		pred = apply_list_op(r.item);
		pending_results.push_back(r.typed ? r.want : pred);
		if (calm) begin
			// no gaps in this stretch
		end else if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end else begin
			burst_left--;
		end
	endtask

	// hold off until every result is back
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		@(posedge clk);
	endtask

	// stimulus
	initial begin
		directed_rows.push_back(row(OP_READ,    0,   32'h0,
			1'b1, res(ST_ERR, 32'h0, 0, 1'b1, 32'h0)));
		directed_rows.push_back(row(OP_DELETE,  0,   32'h0,
			1'b1, res(ST_ERR, 32'h0, 0, 1'b1, 32'h0)));
		directed_rows.push_back(row(OP_REPLACE, 0,   32'h1,
			1'b1, res(ST_ERR, 32'h0, 0, 1'b1, 32'h0)));
		directed_rows.push_back(row(OP_INSERT,  255, 32'hFFFF_FFFF,
			1'b1, res(ST_OK, 32'h0, 1, 1'b0, 32'hFFFF_FFFF)));
		directed_rows.push_back(row(OP_INSERT,  0,   32'h0,
			1'b1, res(ST_OK, 32'h0, 2, 1'b0, 32'hFFFF_FFFF)));
		directed_rows.push_back(row(OP_READ,    0,   32'h0,
			1'b1, res(ST_OK, 32'h0, 2, 1'b0, 32'hFFFF_FFFF)));
		directed_rows.push_back(row(OP_READ,    1,   32'h0,
			1'b1, res(ST_OK, 32'hFFFF_FFFF, 2, 1'b0, 32'hFFFF_FFFF)));
		directed_rows.push_back(row(OP_READ,    255, 32'h0,
			1'b1, res(ST_ERR, 32'h0, 2, 1'b0, 32'hFFFF_FFFF)));
		directed_rows.push_back(row(OP_INSERT,  1,   32'hA5A5_A5A5, 1'b0, '0));
		directed_rows.push_back(row(OP_INSERT,  3,   32'h1234_5678, 1'b0, '0));
		directed_rows.push_back(row(OP_REPLACE, 3,   32'h5A5A_5A5A, 1'b0, '0));
		directed_rows.push_back(row(OP_REPLACE, 4,   32'hDEAD_BEEF, 1'b0, '0));
		directed_rows.push_back(row(OP_REPLACE, 255, 32'h0F0F_0F0F, 1'b0, '0));
		directed_rows.push_back(row(OP_READ,    2,   32'h0,         1'b0, '0));
		directed_rows.push_back(row(OP_DELETE,  255, 32'h0,         1'b0, '0));
		directed_rows.push_back(row(OP_DELETE,  0,   32'h0,         1'b0, '0));
		directed_rows.push_back(row(OP_DELETE,  1,   32'h0,         1'b0, '0));
		directed_rows.push_back(row(OP_RSVD5,   0,   32'h7777_7777, 1'b0, '0));
		directed_rows.push_back(row(OP_RSVD6,   170, 32'h0,         1'b0, '0));
		directed_rows.push_back(row(OP_RSVD7,   85,  32'hFFFF_FFFF, 1'b0, '0));
		directed_rows.push_back(row(OP_CLEAR,   0,   32'h0,
			1'b1, res(ST_OK, 32'h0, 0, 1'b1, 32'h0)));
		directed_rows.push_back(row(OP_CLEAR,   255, 32'hFFFF_FFFF,
			1'b1, res(ST_OK, 32'h0, 0, 1'b1, 32'h0)));
		directed_rows.push_back(row(OP_INSERT,  0,   32'h8000_0001,
			1'b1, res(ST_OK, 32'h0, 1, 1'b0, 32'h8000_0001)));
		directed_rows.push_back(row(OP_DELETE,  0,   32'h0,
			1'b1, res(ST_OK, 32'h0, 0, 1'b1, 32'h0)));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_row(directed_rows[i]);
		drain_results();

		for (int ph = 0; ph < 9; ph++) begin
			calm = phase_calm[ph];
			burst_left = 0;
			repeat (phase_len[ph])
				send_row(rand_row(phase_kind[ph]));
			drain_results();
		end

		repeat (SETTLE) @(posedge clk);
		if (bad_results == 0 && pending_results.size() == 0)
			$display("PASS positional_list_engine_top");
		else
			$display("FAIL positional_list_engine_top");
		$finish;
	end

	// result checking and receiver stall pattern
	always @(posedge clk) begin
		list_result_t got;
		list_result_t want;
		logic         bad;
		rcv_tick <= rcv_tick + 16'd1;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[OUT_W_USED-1:0];
			if (pending_results.size() == 0) begin
				bad_results++;
				if (bad_results <= MAX_SHOWN)
					$display("unexpected result item: st=%0d el=%h cnt=%0d empty=%0d last=%h",
						got.status, got.element_out, got.entry_count, got.is_empty,
						got.last_element);
			end else begin
				want = pending_results.pop_front();
				bad = (got.status !== want.status) ||
					(got.element_out !== want.element_out) ||
					(got.entry_count !== want.entry_count) ||
					(got.is_empty !== want.is_empty) ||
					(got.last_element !== want.last_element);
				if (bad) begin
					bad_results++;
					if (bad_results <= MAX_SHOWN) begin
						$display("result mismatch: exp st=%0d el=%h cnt=%0d empty=%0d last=%h",
							want.status, want.element_out, want.entry_count,
							want.is_empty, want.last_element);
						$display("                 got st=%0d el=%h cnt=%0d empty=%0d last=%h",
							got.status, got.element_out, got.entry_count,
							got.is_empty, got.last_element);
					end
				end
			end
		end
		if (rcv_left == 0) begin
			rcv_mode <= 2'($urandom_range(0, 3));
			rcv_left <= $urandom_range(16, 96);
		end else begin
			rcv_left <= rcv_left - 1;
		end
		case (rcv_mode)
			RCV_STEADY: m_tready <= 1'b1;
			RCV_SKIP:   m_tready <= (rcv_tick[1:0] != 2'b11);
			RCV_COIN:   m_tready <= 1'($urandom_range(0, 1));
			RCV_LONG:   m_tready <= (rcv_tick[3:0] >= 4'd12);
			default:    m_tready <= 1'b1;
		endcase
	end

	// watchdog
	initial begin
		while (cycle_cnt < RUN_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("FAIL positional_list_engine_top");
		$finish;
	end

endmodule
